[rtl/core/tnfd_pkg.sv]
// Shared types and constants for the tar numeric field decoder.
// No dependencies; every other file of the block but tnfd_if.sv refers to this package.
package tnfd_pkg;

	localparam int VALUE_BITS  = 64;  // width of the decoded value, 16..64
	localparam int VALUE_W     = 64;  // width of the value port
	localparam int STATUS_W    = 2;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BADTERM  = 2'd2;

	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_SEVEN = 8'h37;
	localparam logic [7:0] CHAR_NUL   = 8'h00;

	typedef enum logic [2:0] {
		PH_START,
		PH_B256,
		PH_SKIP,
		PH_DIGITS,
		PH_DONE
	} phase_t;

	// one classified byte as it travels through the queue
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       is_digit;
		logic       is_nul;
		logic [2:0] digit;
	} entry_t;

	typedef struct packed {
		logic   valid;
		entry_t entry;
	} push_t;

endpackage

[rtl/core/tnfd_if.sv]
// Stream interfaces for the byte input and the result output channels.
// Depends on no package; widths are fixed by the field formats.
interface tnfd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] field_byte;
	logic       last_byte;

	modport source(output valid, output field_byte, output last_byte, input ready);
	modport sink(input valid, input field_byte, input last_byte, output ready);
endinterface

interface tnfd_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] value;
	logic [1:0]  status;

	modport source(output valid, output value, output status, input ready);
	modport sink(input valid, input value, input status, output ready);
endinterface

[rtl/core/tar_numeric_field_decoder.sv]
// Top level of the tar numeric field decoder: front, queue and back end.
// Uses tnfd_pkg, tnfd_if, tnfd_front, tnfd_queue and tnfd_back.
//
//   channel     dir  payload                       handshake
//   byte_in     in   field_byte[7:0], last_byte    valid/ready
//   result_out  out  value[63:0], status[1:0]      valid/ready
//
// One byte per cycle sustained unless a stalled result fills the queue; a result is offered
// from the output register after its last byte has passed the four-entry queue and the back end.
// The rate is set by the shift-and-insert update in the back end.
// arst_n clears the queue, the field state and the output valid.
// A stalled result holds only last bytes; other bytes keep draining the queue,
// and byte_in drops ready only when the queue is full.
module tar_numeric_field_decoder (
	input  logic        clk,
	input  logic        arst_n,
	tnfd_in_if.sink     byte_in,
	tnfd_out_if.source  result_out
);

	tnfd_pkg::push_t   push;
	tnfd_pkg::entry_t  head;
	logic              queue_full;
	logic              head_valid;
	logic              pop;

	tnfd_front u_front (
		.byte_in    (byte_in),
		.queue_full (queue_full),
		.push       (push)
	);

	tnfd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	tnfd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.result_out (result_out)
	);

endmodule

[rtl/core/tnfd_front.sv]
// Front end: accepts field bytes and classifies them for the back end.
// Uses tnfd_pkg and tnfd_in_if; feeds tnfd_queue.
module tnfd_front (
	tnfd_in_if.sink          byte_in,
	input  logic             queue_full,
	output tnfd_pkg::push_t  push
);

	logic [7:0] b;

	assign b              = byte_in.field_byte;
	assign byte_in.ready  = !queue_full;

	always_comb begin
		push.valid          = byte_in.valid;
		push.entry.data     = b;
		push.entry.last     = byte_in.last_byte;
		push.entry.is_digit = (b >= tnfd_pkg::CHAR_ZERO) && (b <= tnfd_pkg::CHAR_SEVEN);
		push.entry.is_nul   = (b == tnfd_pkg::CHAR_NUL);
		push.entry.digit    = b[2:0];
	end

endmodule

[rtl/core/tnfd_queue.sv]
// Short FIFO of classified bytes between the front and back ends.
// Uses tnfd_pkg.
module tnfd_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  tnfd_pkg::push_t   push,
	output logic              full,
	input  logic              pop,
	output logic              head_valid,
	output tnfd_pkg::entry_t  head
);

	tnfd_pkg::entry_t                   slot_q [tnfd_pkg::QUEUE_DEPTH];
	logic [tnfd_pkg::QUEUE_PTR_W-1:0]   wptr_q;
	logic [tnfd_pkg::QUEUE_PTR_W-1:0]   rptr_q;
	logic [tnfd_pkg::QUEUE_CNT_W-1:0]   count_q;
	logic                               do_push;
	logic                               do_pop;

	assign full       = (count_q == tnfd_pkg::QUEUE_CNT_W'(tnfd_pkg::QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = slot_q[rptr_q];
	assign do_push    = push.valid && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wptr_q] <= push.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= tnfd_pkg::QUEUE_CNT_W'(tnfd_pkg::QUEUE_DEPTH))
		else $error("queue count beyond depth");

endmodule

[rtl/core/tnfd_back.sv]
// Back end: runs the field state machine on queued bytes and holds the result.
// Uses tnfd_pkg and tnfd_out_if; takes entries from tnfd_queue.
module tnfd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  tnfd_pkg::entry_t  head,
	output logic              pop,
	tnfd_out_if.source        result_out
);

	localparam int VB = tnfd_pkg::VALUE_BITS;

	tnfd_pkg::phase_t                 phase_q, phase_n, phase_d;
	logic [VB-1:0]                    acc_q, acc_n, acc_d;
	logic [tnfd_pkg::STATUS_W-1:0]    err_q, err_n, err_d;
	logic [VB+7:0]                    wide8;
	logic [VB+2:0]                    wide3;
	logic [VB-1:0]                    shift8;
	logic [VB-1:0]                    shift3;
	logic                             ovf8;
	logic                             ovf3;

	logic                             out_valid_q;
	logic [tnfd_pkg::VALUE_W-1:0]     value_q;
	logic [tnfd_pkg::STATUS_W-1:0]    status_q;

	assign wide8  = {acc_q, head.data};
	assign wide3  = {acc_q, head.digit};
	assign shift8 = wide8[VB-1:0];
	assign shift3 = wide3[VB-1:0];
	assign ovf8   = (acc_q[VB-1 -: 8] != '0);
	assign ovf3   = (acc_q[VB-1 -: 3] != '0);

	// a last byte needs the output register free, other bytes always advance
	assign pop = head_valid && (!head.last || !out_valid_q || result_out.ready);

	always_comb begin
		phase_n = phase_q;
		acc_n   = acc_q;
		err_n   = err_q;
		unique case (phase_q) inside
			tnfd_pkg::PH_START: begin
				err_n = tnfd_pkg::ST_OK;
				if (head.data[7]) begin
					acc_n   = VB'(head.data[5:0]);
					phase_n = tnfd_pkg::PH_B256;
				end else if (head.is_digit) begin
					acc_n   = VB'(head.digit);
					phase_n = tnfd_pkg::PH_DIGITS;
				end else begin
					acc_n   = '0;
					phase_n = tnfd_pkg::PH_SKIP;
				end
			end
			tnfd_pkg::PH_B256: begin
				if (ovf8) begin
					err_n   = tnfd_pkg::ST_OVERFLOW;
					phase_n = tnfd_pkg::PH_DONE;
				end else begin
					acc_n = shift8;
				end
			end
			tnfd_pkg::PH_SKIP, tnfd_pkg::PH_DIGITS: begin
				if (head.is_digit) begin
					if (ovf3) begin
						err_n   = tnfd_pkg::ST_OVERFLOW;
						phase_n = tnfd_pkg::PH_DONE;
					end else begin
						acc_n   = shift3;
						phase_n = tnfd_pkg::PH_DIGITS;
					end
				end else if (phase_q == tnfd_pkg::PH_DIGITS) begin
					if (!head.is_nul) begin
						err_n = tnfd_pkg::ST_BADTERM;
					end
					phase_n = tnfd_pkg::PH_DONE;
				end
			end
			tnfd_pkg::PH_DONE: begin
				// drop bytes until the end of the field
			end
			default: begin
				phase_n = tnfd_pkg::PH_START;
			end
		endcase

		phase_d = phase_n;
		acc_d   = acc_n;
		err_d   = err_n;
		if (head.last) begin
			phase_d = tnfd_pkg::PH_START;
			acc_d   = '0;
			err_d   = tnfd_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= tnfd_pkg::PH_START;
			acc_q   <= '0;
			err_q   <= tnfd_pkg::ST_OK;
		end else if (pop) begin
			phase_q <= phase_d;
			acc_q   <= acc_d;
			err_q   <= err_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && head.last) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.last) begin
			value_q  <= (err_n == tnfd_pkg::ST_OK) ? tnfd_pkg::VALUE_W'(acc_n) : '0;
			status_q <= err_n;
		end
	end

	assign result_out.valid  = out_valid_q;
	assign result_out.value  = value_q;
	assign result_out.status = status_q;

	a_err_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (status_q != tnfd_pkg::ST_OK) |-> (value_q == '0))
		else $error("value not zero on error status");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (status_q == tnfd_pkg::ST_OK) || (status_q == tnfd_pkg::ST_OVERFLOW)
			|| (status_q == tnfd_pkg::ST_BADTERM))
		else $error("undefined status code");

	a_err_done: assert property (@(posedge clk) disable iff (!arst_n)
		(err_q != tnfd_pkg::ST_OK) |-> (phase_q == tnfd_pkg::PH_DONE))
		else $error("error recorded outside done phase");

	a_result_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		pop && head.last |=> out_valid_q)
		else $error("last byte gave no result");

endmodule
